// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dnsar_pkg.sv
// Types and constants of the DNS A-record response parser.
package dnsar_pkg;

   // Bytes beyond this count are dropped
   localparam int unsigned MAX_MESSAGE_BYTES = 512;
   localparam int unsigned POS_WIDTH = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [POS_WIDTH-1:0] MAX_POS = POS_WIDTH'(MAX_MESSAGE_BYTES);
   localparam logic [POS_WIDTH-1:0] HEADER_BYTES = POS_WIDTH'(12);

   // Label byte and header flag byte fields
   localparam logic [7:0] LABEL_TYPE_MASK = 8'hC0;
   localparam logic [7:0] MAX_LABEL_LEN = 8'd63;
   localparam logic [7:0] RESPONSE_BIT = 8'h80;
   localparam logic [7:0] RCODE_MASK = 8'h0F;

   // Record fields
   localparam logic [15:0] TYPE_A = 16'd1;
   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [15:0] A_RDATA_LEN = 16'd4;
   localparam logic [3:0] QFIXED_BYTES = 4'd4;
   localparam logic [3:0] AFIXED_BYTES = 4'd10;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_ID_MISMATCH = 3'd2,
      ST_NOT_RESP   = 3'd3,
      ST_RCODE      = 3'd4,
      ST_BAD_NAME   = 3'd5,
      ST_TRUNCATED  = 3'd6,
      ST_NO_A       = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_NAME   = 4'd1,
      PH_LABEL  = 4'd2,
      PH_PTR    = 4'd3,
      PH_QFIXED = 4'd4,
      PH_AFIXED = 4'd5,
      PH_RDATA  = 4'd6,
      PH_DONE   = 4'd7,
      PH_STOP   = 4'd8
   } phase_type;

   // One accepted input beat
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } beat_type;

   // Verdict for the message, meaningful on a last beat
   typedef struct packed {
      logic        resolved;
      logic [31:0] host_address;
      status_type  status;
   } result_type;

endpackage

// File: hw/rtl/dnsar_if.sv
// Valid/ready channel interfaces for the request bytes and the parse result.
interface dnsar_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsar_rsp_if;
   logic        valid;
   logic        ready;
   logic        resolved;
   logic [31:0] host_address;
   logic [2:0]  status;

   modport source (output valid, output resolved, output host_address, output status,
                   input ready);
   modport sink (input valid, input resolved, input host_address, input status,
                 output ready);
endinterface

// File: hw/rtl/dnsar_engine.sv
// Byte-at-a-time DNS message walker: header checks, name skipping, A record capture.
module dnsar_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  dnsar_pkg::beat_type   beat,
   input  logic [15:0]           expected_id,
   output dnsar_pkg::result_type result
);

   // Header byte offsets
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_ID_HI = dnsar_pkg::POS_WIDTH'(0);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_ID_LO = dnsar_pkg::POS_WIDTH'(1);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_FLAGS = dnsar_pkg::POS_WIDTH'(2);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_RCODE = dnsar_pkg::POS_WIDTH'(3);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_QD_HI = dnsar_pkg::POS_WIDTH'(4);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_QD_LO = dnsar_pkg::POS_WIDTH'(5);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_AN_HI = dnsar_pkg::POS_WIDTH'(6);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_AN_LO = dnsar_pkg::POS_WIDTH'(7);
   localparam logic [dnsar_pkg::POS_WIDTH-1:0] OFS_HDR_END = dnsar_pkg::POS_WIDTH'(11);

   // Answer fixed-part offsets
   localparam logic [3:0] AF_TYPE_HI  = 4'd0;
   localparam logic [3:0] AF_TYPE_LO  = 4'd1;
   localparam logic [3:0] AF_CLASS_HI = 4'd2;
   localparam logic [3:0] AF_CLASS_LO = 4'd3;
   localparam logic [3:0] AF_RDLEN_HI = 4'd8;
   localparam logic [3:0] AF_RDLEN_LO = 4'd9;

   logic [dnsar_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   dnsar_pkg::phase_type            phase_ff, phase_in;
   logic [15:0]                     qleft_ff, qleft_in;
   logic [15:0]                     aleft_ff, aleft_in;
   logic [15:0]                     skip_ff, skip_in;
   logic [3:0]                      field_ff, field_in;
   logic [15:0]                     rtype_ff, rtype_in;
   logic [15:0]                     rclass_ff, rclass_in;
   logic [15:0]                     rdlen_ff, rdlen_in;
   logic [31:0]                     addr_ff, addr_in;
   logic                            found_ff, found_in;
   dnsar_pkg::status_type           fail_ff, fail_in;

   logic [7:0]  b;
   logic [15:0] aleft_dec;
   logic [15:0] qleft_dec;
   logic [15:0] skip_dec;
   logic [3:0]  field_inc;
   logic        is_a;

   assign b         = beat.data;
   assign aleft_dec = aleft_ff - 16'd1;
   assign qleft_dec = qleft_ff - 16'd1;
   assign skip_dec  = skip_ff - 16'd1;
   assign field_inc = field_ff + 4'd1;
   assign is_a      = (rtype_ff == dnsar_pkg::TYPE_A) && (rclass_ff == dnsar_pkg::CLASS_IN)
                      && (rdlen_ff == dnsar_pkg::A_RDATA_LEN);

   // Parse state after taking this beat
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      qleft_in  = qleft_ff;
      aleft_in  = aleft_ff;
      skip_in   = skip_ff;
      field_in  = field_ff;
      rtype_in  = rtype_ff;
      rclass_in = rclass_ff;
      rdlen_in  = rdlen_ff;
      addr_in   = addr_ff;
      found_in  = found_ff;
      fail_in   = fail_ff;
      if (beat.valid && (pos_ff < dnsar_pkg::MAX_POS)) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            dnsar_pkg::PH_HEADER: begin
               if (pos_ff == OFS_ID_HI) begin
                  rtype_in = {b, 8'h00};
               end else if (pos_ff == OFS_ID_LO) begin
                  rtype_in = {rtype_ff[15:8], b};
                  if ({rtype_ff[15:8], b} != expected_id) begin
                     fail_in  = dnsar_pkg::ST_ID_MISMATCH;
                     phase_in = dnsar_pkg::PH_STOP;
                  end
               end else if (pos_ff == OFS_FLAGS) begin
                  if ((b & dnsar_pkg::RESPONSE_BIT) == 8'h00) begin
                     fail_in  = dnsar_pkg::ST_NOT_RESP;
                     phase_in = dnsar_pkg::PH_STOP;
                  end
               end else if (pos_ff == OFS_RCODE) begin
                  if ((b & dnsar_pkg::RCODE_MASK) != 8'h00) begin
                     fail_in  = dnsar_pkg::ST_RCODE;
                     phase_in = dnsar_pkg::PH_STOP;
                  end
               end else if (pos_ff == OFS_QD_HI) begin
                  qleft_in = {b, 8'h00};
               end else if (pos_ff == OFS_QD_LO) begin
                  qleft_in = {qleft_ff[15:8], b};
               end else if (pos_ff == OFS_AN_HI) begin
                  aleft_in = {b, 8'h00};
               end else if (pos_ff == OFS_AN_LO) begin
                  aleft_in = {aleft_ff[15:8], b};
               end
               // End of header: go to questions, answers or straight to done
               if (pos_ff == OFS_HDR_END) begin
                  rtype_in = 16'h0000;
                  if (qleft_ff != 16'h0000 || aleft_ff != 16'h0000) begin
                     phase_in = dnsar_pkg::PH_NAME;
                  end else begin
                     phase_in = dnsar_pkg::PH_DONE;
                  end
               end
            end
            dnsar_pkg::PH_NAME: begin
               if (b == 8'h00) begin
                  field_in = 4'd0;
                  phase_in = (qleft_ff != 16'h0000) ? dnsar_pkg::PH_QFIXED
                                                    : dnsar_pkg::PH_AFIXED;
               end else if ((b & dnsar_pkg::LABEL_TYPE_MASK) == dnsar_pkg::LABEL_TYPE_MASK) begin
                  phase_in = dnsar_pkg::PH_PTR;
               end else if ((b & dnsar_pkg::LABEL_TYPE_MASK) != 8'h00
                            || b > dnsar_pkg::MAX_LABEL_LEN) begin
                  fail_in  = dnsar_pkg::ST_BAD_NAME;
                  phase_in = dnsar_pkg::PH_STOP;
               end else begin
                  skip_in  = {8'h00, b};
                  phase_in = dnsar_pkg::PH_LABEL;
               end
            end
            dnsar_pkg::PH_LABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'h0000) begin
                  phase_in = dnsar_pkg::PH_NAME;
               end
            end
            dnsar_pkg::PH_PTR: begin
               // Second pointer byte ends the name
               field_in = 4'd0;
               phase_in = (qleft_ff != 16'h0000) ? dnsar_pkg::PH_QFIXED
                                                 : dnsar_pkg::PH_AFIXED;
            end
            dnsar_pkg::PH_QFIXED: begin
               field_in = field_inc;
               if (field_inc >= dnsar_pkg::QFIXED_BYTES) begin
                  field_in = 4'd0;
                  qleft_in = qleft_dec;
                  if (qleft_dec != 16'h0000 || aleft_ff != 16'h0000) begin
                     phase_in = dnsar_pkg::PH_NAME;
                  end else begin
                     phase_in = dnsar_pkg::PH_DONE;
                  end
               end
            end
            dnsar_pkg::PH_AFIXED: begin
               if (field_ff == AF_TYPE_HI) begin
                  rtype_in = {b, 8'h00};
               end else if (field_ff == AF_TYPE_LO) begin
                  rtype_in = {rtype_ff[15:8], b};
               end else if (field_ff == AF_CLASS_HI) begin
                  rclass_in = {b, 8'h00};
               end else if (field_ff == AF_CLASS_LO) begin
                  rclass_in = {rclass_ff[15:8], b};
               end else if (field_ff == AF_RDLEN_HI) begin
                  rdlen_in = {b, 8'h00};
               end else if (field_ff == AF_RDLEN_LO) begin
                  rdlen_in = {rdlen_ff[15:8], b};
               end
               field_in = field_inc;
               if (field_inc >= dnsar_pkg::AFIXED_BYTES) begin
                  field_in = 4'd0;
                  if (rdlen_in == 16'h0000) begin
                     aleft_in = aleft_dec;
                     phase_in = (aleft_dec != 16'h0000) ? dnsar_pkg::PH_NAME
                                                        : dnsar_pkg::PH_DONE;
                  end else begin
                     skip_in  = rdlen_in;
                     addr_in  = 32'h0000_0000;
                     phase_in = dnsar_pkg::PH_RDATA;
                  end
               end
            end
            dnsar_pkg::PH_RDATA: begin
               if (is_a) begin
                  addr_in = {addr_ff[23:0], b};
               end
               skip_in = skip_dec;
               if (skip_dec == 16'h0000) begin
                  if (is_a) begin
                     found_in = 1'b1;
                     phase_in = dnsar_pkg::PH_DONE;
                  end else begin
                     aleft_in = aleft_dec;
                     phase_in = (aleft_dec != 16'h0000) ? dnsar_pkg::PH_NAME
                                                        : dnsar_pkg::PH_DONE;
                  end
               end
            end
            default: begin
               // done or stopped: bytes are dropped
            end
         endcase
      end
   end

   // Verdict from the state as it stands after this beat
   always_comb begin
      if (pos_in < dnsar_pkg::HEADER_BYTES) begin
         result.status = dnsar_pkg::ST_SHORT;
      end else if (fail_in != dnsar_pkg::ST_OK) begin
         result.status = fail_in;
      end else if (found_in) begin
         result.status = dnsar_pkg::ST_OK;
      end else if (phase_in == dnsar_pkg::PH_DONE) begin
         result.status = dnsar_pkg::ST_NO_A;
      end else begin
         result.status = dnsar_pkg::ST_TRUNCATED;
      end
      result.resolved     = (result.status == dnsar_pkg::ST_OK);
      result.host_address = result.resolved ? addr_in : 32'h0000_0000;
   end

   // State registers; a last beat clears everything for the next message
   always_ff @(posedge clock) begin
      if (reset || (beat.valid && beat.last)) begin
         pos_ff    <= '0;
         phase_ff  <= dnsar_pkg::PH_HEADER;
         qleft_ff  <= 16'h0000;
         aleft_ff  <= 16'h0000;
         skip_ff   <= 16'h0000;
         field_ff  <= 4'd0;
         rtype_ff  <= 16'h0000;
         rclass_ff <= 16'h0000;
         rdlen_ff  <= 16'h0000;
         addr_ff   <= 32'h0000_0000;
         found_ff  <= 1'b0;
         fail_ff   <= dnsar_pkg::ST_OK;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         qleft_ff  <= qleft_in;
         aleft_ff  <= aleft_in;
         skip_ff   <= skip_in;
         field_ff  <= field_in;
         rtype_ff  <= rtype_in;
         rclass_ff <= rclass_in;
         rdlen_ff  <= rdlen_in;
         addr_ff   <= addr_in;
         found_ff  <= found_in;
         fail_ff   <= fail_in;
      end
   end

endmodule

// File: hw/rtl/dns_a_record_response_parser.sv
// DNS A-record response parser top level: channels, id register, result register.
//
// Usage: the message bytes of one DNS response stream in on req_chan, one byte
// per beat, with last_byte set on the final beat. The header is checked against
// the expected transaction id written on csr_wr_en/csr_wr_data (write only while
// no message is in flight). Question names are skipped and the first answer of
// type A, class IN with a 4-byte rdata gives the address.
// Throughput: one byte per cycle unless stalled (see below); each beat is folded into
// the parse state in the cycle it is accepted, with no bubbles between messages.
// Result: the result beat (resolved, host_address, status) shows on rsp_chan in
// the cycle after the last byte is accepted; other bytes give no result.
// Stall: the result register holds one result. While it is full and rsp_chan
// is not ready, req_chan.ready drops; it is high whenever the register is empty
// or being drained in the same cycle.
// Reset: synchronous, clears the parse state, the result valid flag and the id
// register (to zero).
module dns_a_record_response_parser (
   input  logic               clock,
   input  logic               reset,
   dnsar_req_if.sink          req_chan,
   dnsar_rsp_if.source        rsp_chan,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0]           expected_id_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_resolved_ff;
   logic [31:0]           rsp_address_ff;
   logic [2:0]            rsp_status_ff;
   logic                  req_ready;
   dnsar_pkg::beat_type   beat;
   dnsar_pkg::result_type result;

   // Accept while the result slot is empty or draining
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = req_ready;

   assign beat.valid = req_chan.valid && req_ready;
   assign beat.last  = req_chan.last_byte;
   assign beat.data  = req_chan.data_byte;

   // Transaction id register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'h0000;
      end else if (csr_wr_en) begin
         expected_id_ff <= csr_wr_data;
      end
   end

   dnsar_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .expected_id (expected_id_ff),
      .result      (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat.valid && beat.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat.valid && beat.last) begin
         rsp_resolved_ff <= result.resolved;
         rsp_address_ff  <= result.host_address;
         rsp_status_ff   <= result.status;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.resolved     = rsp_resolved_ff;
   assign rsp_chan.host_address = rsp_address_ff;
   assign rsp_chan.status       = rsp_status_ff;

endmodule

// File: hw/rtl/dnsar_checker.sv
// Port-level checks of the DNS A-record response parser and their bind.
`include "assert_macros.svh"

module dnsar_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_resolved,
   input logic [31:0] rsp_host_address,
   input logic [2:0]  rsp_status
);

   // A stalled result beat keeps its contents
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_host_address) && $stable(rsp_resolved), "rsp beat changed while stalled")

   // resolved agrees with an ok status
   `ASSERT_RST(a_resolved_ok, clock, reset, rsp_valid |-> (rsp_resolved == (rsp_status == dnsar_pkg::ST_OK)), "resolved disagrees with status")

   // No address without a resolved result
   `ASSERT_RST(a_addr_zero, clock, reset, rsp_valid && !rsp_resolved |-> rsp_host_address == 32'h0000_0000, "address set on unresolved result")

   // The input side is open whenever no result is waiting
   `ASSERT_RST(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "input blocked with empty result slot")

   // Reset empties the result slot
   `ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind dns_a_record_response_parser dnsar_checker u_dnsar_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_resolved     (rsp_chan.resolved),
   .rsp_host_address (rsp_chan.host_address),
   .rsp_status       (rsp_chan.status)
);
